>>> src/gdps_pkg.sv
// Shared types, constants and register codes of the glow disc pixel shader.
`timescale 1ns / 1ps
package gdps_pkg;

    // Pixel coordinates use only their low PIXEL_BITS bits.
    localparam int PIXEL_BITS = 12;
    localparam int PIX_W      = 12;
    localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((64'd1 << PIXEL_BITS) - 64'd1);

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 48;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CENTER_X    = 3'd0,
        CFG_CENTER_Y    = 3'd1,
        CFG_OUTER_R2    = 3'd2,
        CFG_DEPTH_SCALE = 3'd3,
        CFG_FRONT_CLR   = 3'd4,
        CFG_INNER_R2    = 3'd5,
        CFG_FALLOFF     = 3'd6,
        CFG_HOLLOW      = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OUTC_OUTSIDE = 2'd0,
        OUTC_CULLED  = 2'd1,
        OUTC_INNER   = 2'd2,
        OUTC_RING    = 2'd3
    } outcome_t;

    // Digit-by-digit square root: 58-bit radicand, two bits per stage.
    localparam int SQ_RAD_W  = 58;
    localparam int SQ_STEPS  = SQ_RAD_W / 2;
    localparam int SQ_ROOT_W = SQ_STEPS;
    localparam int SQ_REM_W  = SQ_ROOT_W + 3;

    // Quarter sine polynomial, Q1.30 coefficients.
    localparam int SIN_X_W  = 31;
    localparam int SIN_SV_W = 34;
    localparam int SIN_LAT  = 8;
    localparam logic [30:0] SIN_A1 = 31'd1686629713;
    localparam logic [30:0] SIN_A3 = 31'd693598668;
    localparam logic [30:0] SIN_A5 = 31'd85569306;
    localparam logic [30:0] SIN_A7 = 31'd5026995;
    localparam logic [30:0] SIN_A9 = 31'd172272;

    localparam logic [34:0] TENTH_Q30  = 35'd107374182;
    localparam logic [34:0] ROUND_Q15  = 35'd16384;
    localparam logic [15:0] ONE_Q15    = 16'd32768;
    localparam logic [15:0] INTENS_MAX = 16'd36045;

    typedef struct packed {
        logic miss;
        logic inner;
    } side_t;

    typedef struct packed {
        outcome_t    outcome;
        logic [23:0] depth;
    } shade_t;

endpackage

>>> src/gdps_sqrt.sv
// Pipelined floor square root, one result bit resolved per register stage.
`timescale 1ns / 1ps
module gdps_sqrt (
    input  logic                            aclk,
    input  logic                            en,
    input  logic [gdps_pkg::SQ_RAD_W-1:0]   radicand,
    output logic [gdps_pkg::SQ_ROOT_W-1:0]  root
);
    import gdps_pkg::*;

    logic [SQ_REM_W-1:0]  rem_reg  [SQ_STEPS];
    logic [SQ_ROOT_W-1:0] root_reg [SQ_STEPS];
    logic [SQ_RAD_W-1:0]  rad_reg  [SQ_STEPS];

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_step
        logic [SQ_REM_W-1:0]  rem_in;
        logic [SQ_ROOT_W-1:0] root_in;
        logic [SQ_RAD_W-1:0]  rad_in;
        logic [SQ_REM_W-1:0]  rem_sh;
        logic [SQ_REM_W-1:0]  trial;

        if (g == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
        end else begin : g_rest
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign rad_in  = rad_reg[g-1];
        end

        // Bring down the next two radicand bits and try the next root bit.
        assign rem_sh = {rem_in[SQ_REM_W-3:0], rad_in[SQ_RAD_W-1 -: 2]};
        assign trial  = {1'b0, root_in, 2'b01};

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_sh >= trial) begin
                    rem_reg[g]  <= rem_sh - trial;
                    root_reg[g] <= {root_in[SQ_ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg[g]  <= rem_sh;
                    root_reg[g] <= {root_in[SQ_ROOT_W-2:0], 1'b0};
                end
                rad_reg[g] <= {rad_in[SQ_RAD_W-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[SQ_STEPS-1];

endmodule

>>> src/gdps_sin.sv
// Pipelined quarter-wave sine polynomial in Q1.30 fixed point.
`timescale 1ns / 1ps
module gdps_sin (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [gdps_pkg::SIN_X_W-1:0]   x,
    output logic [gdps_pkg::SIN_SV_W-1:0]  sv
);
    import gdps_pkg::*;

    logic [SIN_X_W-1:0] x1_reg, x2_reg, x3_reg, x4_reg, x5_reg;
    logic [SIN_X_W-1:0] sq1_reg, sq2_reg, sq3_reg, sq4_reg;
    logic [SIN_X_W-1:0] p3a_reg, p3b_reg, p3c_reg, p3d_reg;
    logic [SIN_X_W-1:0] p5a_reg, p5b_reg, p5c_reg;
    logic [SIN_X_W-1:0] p7_reg, p7b_reg, p9_reg;
    logic [61:0]        t1_reg, t3_reg, t5_reg, t7_reg, t9_reg;
    logic [63:0]        pos_reg, neg_reg;
    logic [SIN_SV_W-1:0] sv_reg;

    logic [61:0] m_sq_next, m_p3_next, m_p5_next, m_p7_next, m_p9_next;
    logic [63:0] pos_next, neg_next, diff_next;

    assign m_sq_next = 62'(x) * 62'(x);
    assign m_p3_next = 62'(sq1_reg) * 62'(x1_reg);
    assign m_p5_next = 62'(p3a_reg) * 62'(sq2_reg);
    assign m_p7_next = 62'(p5a_reg) * 62'(sq3_reg);
    assign m_p9_next = 62'(p7_reg) * 62'(sq4_reg);

    assign pos_next  = 64'(t1_reg) + 64'(t5_reg) + 64'(t9_reg);
    assign neg_next  = 64'(t3_reg) + 64'(t7_reg);
    assign diff_next = pos_reg - neg_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            // x squared
            x1_reg  <= x;
            sq1_reg <= m_sq_next[60:30];
            // x cubed
            x2_reg  <= x1_reg;
            sq2_reg <= sq1_reg;
            p3a_reg <= m_p3_next[60:30];
            // fifth power
            x3_reg  <= x2_reg;
            sq3_reg <= sq2_reg;
            p3b_reg <= p3a_reg;
            p5a_reg <= m_p5_next[60:30];
            // seventh power
            x4_reg  <= x3_reg;
            sq4_reg <= sq3_reg;
            p3c_reg <= p3b_reg;
            p5b_reg <= p5a_reg;
            p7_reg  <= m_p7_next[60:30];
            // ninth power
            x5_reg  <= x4_reg;
            p3d_reg <= p3c_reg;
            p5c_reg <= p5b_reg;
            p7b_reg <= p7_reg;
            p9_reg  <= m_p9_next[60:30];
            // coefficient products
            t1_reg  <= 62'(SIN_A1) * 62'(x5_reg);
            t3_reg  <= 62'(SIN_A3) * 62'(p3d_reg);
            t5_reg  <= 62'(SIN_A5) * 62'(p5c_reg);
            t7_reg  <= 62'(SIN_A7) * 62'(p7b_reg);
            t9_reg  <= 62'(SIN_A9) * 62'(p9_reg);
            pos_reg <= pos_next;
            neg_reg <= neg_next;
            // A negative polynomial value clamps to zero.
            sv_reg  <= (neg_reg > pos_reg) ? '0 : diff_next[63:30];
        end
    end

    assign sv = sv_reg;

endmodule

>>> src/glow_disc_pixel_shader.sv
// Top level of the glow disc pixel shader: configuration, pipeline and output stage.
`timescale 1ns / 1ps
// Usage:
// Pixels enter on the s_ stream channel, one transaction per pixel, with the
// column and row in s_tdata. Every pixel gives exactly one result transaction
// on the m_ channel: the outcome code in m_tuser, the depth offset and the
// intensity in m_tdata.
// The block is a single pipeline of 47 register stages, and one pixel per cycle
// is sustained while the receiver accepts results.
// The two 29-stage square root pipelines (one bit of root per stage) make up most
// of that depth; the sine polynomial takes another 8 stages.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline freezes and s_tready drops in the same cycle; nothing is lost or
// repeated, and bubbles travel as invalid stages.
// Configuration is written through cfg_wr_en, cfg_addr and cfg_wdata and must
// only change while no pixel is in flight.
// A synchronous active-low reset empties the pipeline and loads the register
// defaults: centre at the origin, zero radii, unit depth scale, the largest
// front clearance, zero gain and a filled inner disc.
module glow_disc_pixel_shader (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [gdps_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [gdps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [23:0]                        s_tdata,  // pixel_x, pixel_y
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [39:0]                        m_tdata,  // depth_offset, intensity
    output logic [1:0]                         m_tuser   // outcome
);
    import gdps_pkg::*;

    localparam int FRONT_STAGES = 7;

    // Configuration registers.
    logic [23:0] center_x_reg, center_y_reg, front_clr_reg;
    logic [47:0] outer_r2_reg, inner_r2_reg;
    logic [31:0] depth_scale_reg, falloff_reg;
    logic        hollow_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            outer_r2_reg    <= '0;
            depth_scale_reg <= 32'h0100_0000;
            front_clr_reg   <= 24'h7F_FFFF;
            inner_r2_reg    <= '0;
            falloff_reg     <= '0;
            hollow_reg      <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_CENTER_X:    center_x_reg    <= cfg_wdata[23:0];
                CFG_CENTER_Y:    center_y_reg    <= cfg_wdata[23:0];
                CFG_OUTER_R2:    outer_r2_reg    <= cfg_wdata[47:0];
                CFG_DEPTH_SCALE: depth_scale_reg <= cfg_wdata[31:0];
                CFG_FRONT_CLR:   front_clr_reg   <= cfg_wdata[23:0];
                CFG_INNER_R2:    inner_r2_reg    <= cfg_wdata[47:0];
                CFG_FALLOFF:     falloff_reg     <= cfg_wdata[31:0];
                CFG_HOLLOW:      hollow_reg      <= cfg_wdata[0];
            endcase
        end
    end

    // Global advance: every stage moves when the output stage can take data.
    logic adv;
    logic m_valid_reg;
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    // Valid bits.
    logic [FRONT_STAGES-1:0] fv_reg;
    logic [SQ_STEPS-1:0]     sq_vld_reg;
    logic                    r1_vld_reg, r2_vld_reg;
    logic [SIN_LAT-1:0]      sin_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg      <= '0;
            sq_vld_reg  <= '0;
            r1_vld_reg  <= 1'b0;
            r2_vld_reg  <= 1'b0;
            sin_vld_reg <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            fv_reg      <= {fv_reg[FRONT_STAGES-2:0], s_tvalid};
            sq_vld_reg  <= {sq_vld_reg[SQ_STEPS-2:0], fv_reg[FRONT_STAGES-1]};
            r1_vld_reg  <= sq_vld_reg[SQ_STEPS-1];
            r2_vld_reg  <= r1_vld_reg;
            sin_vld_reg <= {sin_vld_reg[SIN_LAT-2:0], r2_vld_reg};
            m_valid_reg <= sin_vld_reg[SIN_LAT-1];
        end
    end

    // Front stages: distance, squared distance and depth radicand.
    logic [PIX_W-1:0]  px_reg, py_reg;
    logic [23:0]       mx_reg, my_reg;
    logic [47:0]       sqx_reg, sqy_reg;
    logic [48:0]       k4_reg, k5_reg, k6_reg, k7_reg;
    logic [47:0]       diff_reg;
    logic [55:0]       hp_reg, lp_reg;
    logic [56:0]       d_reg;
    side_t             side5_reg, side6_reg, side7_reg;

    logic signed [24:0] dxs, dys;
    logic [24:0]        dxn, dyn;
    logic [23:0]        mx_next, my_next;

    assign dxs = $signed({5'b0, px_reg, 8'b0}) - $signed({center_x_reg[23], center_x_reg});
    assign dys = $signed({5'b0, py_reg, 8'b0}) - $signed({center_y_reg[23], center_y_reg});
    assign dxn = -dxs;
    assign dyn = -dys;
    assign mx_next = dxs[24] ? dxn[23:0] : dxs[23:0];
    assign my_next = dys[24] ? dyn[23:0] : dys[23:0];

    always_ff @(posedge aclk) begin
        if (adv) begin
            px_reg    <= s_tdata[11:0] & PIX_MASK;
            py_reg    <= s_tdata[23:12] & PIX_MASK;
            mx_reg    <= mx_next;
            my_reg    <= my_next;
            sqx_reg   <= 48'(mx_reg) * 48'(mx_reg);
            sqy_reg   <= 48'(my_reg) * 48'(my_reg);
            k4_reg    <= 49'(sqx_reg) + 49'(sqy_reg);
            k5_reg    <= k4_reg;
            side5_reg <= '{miss: (k4_reg > {1'b0, outer_r2_reg}),
                           inner: (k4_reg <= {1'b0, inner_r2_reg})};
            diff_reg  <= outer_r2_reg - k4_reg[47:0];
            k6_reg    <= k5_reg;
            side6_reg <= side5_reg;
            hp_reg    <= 56'(diff_reg[47:24]) * 56'(depth_scale_reg);
            lp_reg    <= 56'(diff_reg[23:0]) * 56'(depth_scale_reg);
            k7_reg    <= k6_reg;
            side7_reg <= side6_reg;
            d_reg     <= 57'(hp_reg) + 57'(lp_reg[55:24]);
        end
    end

    // Square roots of the depth radicand and of the squared distance.
    logic [SQ_ROOT_W-1:0] height, s_root;

    gdps_sqrt u_sqrt_depth (
        .aclk     (aclk),
        .en       (adv),
        .radicand ({1'b0, d_reg}),
        .root     (height)
    );

    gdps_sqrt u_sqrt_dist (
        .aclk     (aclk),
        .en       (adv),
        .radicand ({9'b0, k7_reg}),
        .root     (s_root)
    );

    side_t side_reg [SQ_STEPS];

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side7_reg;
            for (int i = 1; i < SQ_STEPS; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Cull test, ring gain and sine argument.
    logic [56:0] p_reg;
    logic        cull_reg;
    logic [23:0] hsat_reg;
    side_t       side_r1_reg;
    shade_t      shade_r2_reg;
    logic [SIN_X_W-1:0] x_reg;

    logic        far_next;
    logic [32:0] xd_next;
    shade_t      shade_next;

    assign far_next = p_reg > 57'h1_0000_0000;
    assign xd_next  = 33'h1_0000_0000 - p_reg[32:0];

    always_comb begin
        shade_next.depth = hsat_reg;
        priority if (side_r1_reg.miss) begin
            shade_next.outcome = OUTC_OUTSIDE;
            shade_next.depth   = '0;
        end else if (cull_reg) begin
            shade_next.outcome = OUTC_CULLED;
        end else if (side_r1_reg.inner) begin
            shade_next.outcome = OUTC_INNER;
        end else if (far_next) begin
            shade_next.outcome = OUTC_OUTSIDE;
            shade_next.depth   = '0;
        end else begin
            shade_next.outcome = OUTC_RING;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg        <= 57'(falloff_reg) * 57'(s_root[24:0]);
            cull_reg     <= $signed({1'b0, height}) >
                            $signed({{6{front_clr_reg[23]}}, front_clr_reg});
            hsat_reg     <= (|height[SQ_ROOT_W-1:24]) ? 24'hFF_FFFF : height[23:0];
            side_r1_reg  <= side_reg[SQ_STEPS-1];
            shade_r2_reg <= shade_next;
            x_reg        <= xd_next[32:2];
        end
    end

    // Sine polynomial and matching delay of the result fields.
    logic [SIN_SV_W-1:0] sv;

    gdps_sin u_sin (
        .aclk (aclk),
        .en   (adv),
        .x    (x_reg),
        .sv   (sv)
    );

    shade_t shade_reg [SIN_LAT];

    always_ff @(posedge aclk) begin
        if (adv) begin
            shade_reg[0] <= shade_r2_reg;
            for (int i = 1; i < SIN_LAT; i++) begin
                shade_reg[i] <= shade_reg[i-1];
            end
        end
    end

    // Output stage.
    logic [34:0] ring_sum;
    logic [15:0] intens_next;
    shade_t      shade_out;

    assign shade_out = shade_reg[SIN_LAT-1];
    assign ring_sum  = 35'(sv) + TENTH_Q30 + ROUND_Q15;

    always_comb begin
        unique case (shade_out.outcome)
            OUTC_RING:  intens_next = ring_sum[30:15];
            OUTC_INNER: intens_next = hollow_reg ? 16'd0 : ONE_Q15;
            default:    intens_next = '0;
        endcase
    end

    logic [23:0] depth_out_reg;
    logic [15:0] intens_out_reg;
    outcome_t    outcome_out_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            depth_out_reg   <= shade_out.depth;
            intens_out_reg  <= intens_next;
            outcome_out_reg <= shade_out.outcome;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {intens_out_reg, depth_out_reg};
    assign m_tuser  = outcome_out_reg;

    // A pixel that misses carries no depth and no brightness.
    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (outcome_out_reg == OUTC_OUTSIDE) |-> (m_tdata == 40'd0))
        else $error("outside result with nonzero payload");

    // Culled pixels are never lit.
    a_culled_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (outcome_out_reg == OUTC_CULLED) |-> (intens_out_reg == 16'd0))
        else $error("culled result with nonzero intensity");

    a_intens_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (intens_out_reg <= INTENS_MAX))
        else $error("intensity above its maximum");

    // While the output is stalled the front and root valid bits must not move.
    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(sq_vld_reg) && $stable(fv_reg))
        else $error("pipeline moved during a stall");

endmodule
